[rtl/gclv_pkg.sv]
package gclv_pkg;

	localparam int LINE_CAPACITY_DEF = 256;

	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [8:0] CKSUM_MAX = 9'd511;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NUM,
		PH_GAP,
		PH_CMD,
		PH_CKSUM,
		PH_CKDONE
	} parse_phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NO_CKSUM,
		ST_MISMATCH,
		ST_INJECTED,
		ST_BAD_SEQ
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] line_number;
		logic        has_number;
		logic        line_reset;
		logic [31:0] last_good_line;
		logic [31:0] resend_line;
		logic        ok_after_resend;
	} result_t;

	// characters of the line-number reset command, by position
	function automatic logic [7:0] m110_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = CH_M;
			2'd1:    ch = CH_ONE;
			2'd2:    ch = CH_ONE;
			default: ch = CH_ZERO;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

[rtl/gclv_parser.sv]
module gclv_parser #(
	parameter int LINE_CAPACITY = gclv_pkg::LINE_CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                proc,
	input  logic [7:0]          byte_in,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	output logic                emit,
	output gclv_pkg::result_t   result
);

	localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

	logic [CNT_W-1:0]       stored_q, n_stored;
	gclv_pkg::parse_phase_t phase_q, n_phase;
	logic [7:0]             rx_xor_q, n_rx_xor;
	logic [7:0]             xbs_q, n_xbs;
	logic                   star_q, n_star;
	logic [8:0]             ck_q, n_ck;
	logic [31:0]            acc_q, n_acc;
	logic                   nflag_q, n_nflag;
	logic [2:0]             pos_q, n_pos;
	logic                   match_q, n_match;
	logic [31:0]            last_q, n_last;
	logic                   parity_q, n_parity;
	logic [15:0]            inj_q, n_inj;
	logic [15:0]            every_q;

	logic [7:0]  c;
	logic [3:0]  digit;
	logic [35:0] acc_prod;
	logic [12:0] ck_prod;
	logic        is_m110;
	logic [15:0] inj_inc;
	gclv_pkg::status_t st;

	assign c        = byte_in;
	assign digit    = 4'(c - gclv_pkg::CH_ZERO);
	assign acc_prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, digit};
	assign ck_prod  = {1'b0, ck_q, 3'b000} + {3'b000, ck_q, 1'b0} + {9'd0, digit};
	assign is_m110  = match_q && (pos_q == 3'd4);
	assign inj_inc  = inj_q + 16'd1;

	always_comb begin
		n_stored = stored_q;
		n_phase  = phase_q;
		n_rx_xor = rx_xor_q;
		n_xbs    = xbs_q;
		n_star   = star_q;
		n_ck     = ck_q;
		n_acc    = acc_q;
		n_nflag  = nflag_q;
		n_pos    = pos_q;
		n_match  = match_q;
		n_last   = last_q;
		n_parity = parity_q;
		n_inj    = inj_q;
		emit     = 1'b0;
		st       = gclv_pkg::ST_OK;
		result   = '0;

		if (proc && c != gclv_pkg::CH_CR) begin
			if (c != gclv_pkg::CH_LF) begin
				if (stored_q < CNT_W'(LINE_CAPACITY)) begin
					n_stored = stored_q + CNT_W'(1);
					if (phase_q == gclv_pkg::PH_LEAD) begin
						if (c != gclv_pkg::CH_SPACE) begin
							n_rx_xor = c;
							if (c == gclv_pkg::CH_N) begin
								n_nflag = 1'b1;
								n_phase = gclv_pkg::PH_NUM;
							end else if (c == gclv_pkg::CH_STAR) begin
								// star as first character: its own value is the xor so far
								n_xbs   = c;
								n_star  = 1'b1;
								n_ck    = '0;
								n_match = 1'b0;
								n_phase = gclv_pkg::PH_CKSUM;
							end else begin
								n_phase = gclv_pkg::PH_CMD;
								if (c != gclv_pkg::m110_char(pos_q[1:0])) n_match = 1'b0;
								n_pos = pos_q + 3'd1;
							end
						end
					end else if (c == gclv_pkg::CH_STAR) begin
						n_xbs    = rx_xor_q;
						n_star   = 1'b1;
						n_ck     = '0;
						n_rx_xor = rx_xor_q ^ c;
						if (pos_q < 3'd4) n_match = 1'b0;
						n_phase  = gclv_pkg::PH_CKSUM;
					end else begin
						n_rx_xor = rx_xor_q ^ c;
						case (phase_q)
							gclv_pkg::PH_NUM: begin
								if (gclv_pkg::is_digit(c)) begin
									n_acc = (acc_prod[35:32] != 4'd0) ? 32'hFFFF_FFFF
										: acc_prod[31:0];
								end else if (c == gclv_pkg::CH_SPACE) begin
									n_phase = gclv_pkg::PH_GAP;
								end else begin
									n_phase = gclv_pkg::PH_CMD;
									if (c != gclv_pkg::m110_char(pos_q[1:0])) n_match = 1'b0;
									n_pos = pos_q + 3'd1;
								end
							end
							gclv_pkg::PH_GAP: begin
								if (c != gclv_pkg::CH_SPACE) begin
									n_phase = gclv_pkg::PH_CMD;
									if (c != gclv_pkg::m110_char(pos_q[1:0])) n_match = 1'b0;
									n_pos = pos_q + 3'd1;
								end
							end
							gclv_pkg::PH_CMD: begin
								if (pos_q < 3'd4) begin
									if (c != gclv_pkg::m110_char(pos_q[1:0])) n_match = 1'b0;
									n_pos = pos_q + 3'd1;
								end
							end
							gclv_pkg::PH_CKSUM: begin
								if (gclv_pkg::is_digit(c)) begin
									n_ck = (ck_prod > {4'd0, gclv_pkg::CKSUM_MAX})
										? gclv_pkg::CKSUM_MAX : ck_prod[8:0];
								end else begin
									n_phase = gclv_pkg::PH_CKDONE;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end else begin
				// end of line: verdict only when something past leading spaces came in
				if (phase_q != gclv_pkg::PH_LEAD) begin
					emit = 1'b1;
					if (nflag_q) begin
						if (!star_q) begin
							st = gclv_pkg::ST_NO_CKSUM;
						end else if (ck_q != {1'b0, xbs_q}) begin
							st = gclv_pkg::ST_MISMATCH;
						end else if (is_m110) begin
							n_last = acc_q;
						end else begin
							if (every_q != 16'd0) begin
								n_inj = inj_inc;
								if (inj_inc >= every_q) begin
									n_inj = '0;
									st    = gclv_pkg::ST_INJECTED;
								end
							end
							if (st == gclv_pkg::ST_OK) begin
								if (acc_q != last_q + 32'd1) st = gclv_pkg::ST_BAD_SEQ;
								else n_last = acc_q;
							end
						end
					end
					if (st != gclv_pkg::ST_OK) n_parity = ~parity_q;
					result.status          = st;
					result.line_number     = nflag_q ? acc_q : 32'd0;
					result.has_number      = nflag_q;
					result.line_reset      = is_m110;
					result.last_good_line  = n_last;
					result.resend_line     = n_last + 32'd1;
					result.ok_after_resend = (st != gclv_pkg::ST_OK) && !n_parity;
				end
				n_stored = '0;
				n_phase  = gclv_pkg::PH_LEAD;
				n_rx_xor = '0;
				n_xbs    = '0;
				n_star   = 1'b0;
				n_ck     = '0;
				n_acc    = '0;
				n_nflag  = 1'b0;
				n_pos    = '0;
				n_match  = 1'b1;
			end
		end

		// writing the period restarts the fault counter
		if (cfg_we) n_inj = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			phase_q  <= gclv_pkg::PH_LEAD;
			rx_xor_q <= '0;
			xbs_q    <= '0;
			star_q   <= 1'b0;
			ck_q     <= '0;
			acc_q    <= '0;
			nflag_q  <= 1'b0;
			pos_q    <= '0;
			match_q  <= 1'b1;
			last_q   <= '0;
			parity_q <= 1'b0;
			inj_q    <= '0;
			every_q  <= '0;
		end else begin
			stored_q <= n_stored;
			phase_q  <= n_phase;
			rx_xor_q <= n_rx_xor;
			xbs_q    <= n_xbs;
			star_q   <= n_star;
			ck_q     <= n_ck;
			acc_q    <= n_acc;
			nflag_q  <= n_nflag;
			pos_q    <= n_pos;
			match_q  <= n_match;
			last_q   <= n_last;
			parity_q <= n_parity;
			inj_q    <= n_inj;
			if (cfg_we) every_q <= cfg_data;
		end
	end

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (stored_q == '0) && (phase_q == gclv_pkg::PH_LEAD) && match_q)
		else $error("line state not cleared after verdict");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (inj_q == '0))
		else $error("fault counter not restarted by period write");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_q <= CNT_W'(LINE_CAPACITY)) && (pos_q <= 3'd4))
		else $error("stored count or prefix position out of range");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && st != gclv_pkg::ST_OK) |=> (parity_q != $past(parity_q)))
		else $error("resend parity did not flip on error verdict");

endmodule

[rtl/gclv_out_buf.sv]
module gclv_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gclv_pkg::result_t push_data,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output gclv_pkg::result_t out_data
);

	gclv_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign room      = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push && room) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push && room) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push && room} - {1'b0, pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result buffer count overflow");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && room && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("result buffer did not grow on push");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("result buffer did not shrink on pop");

endmodule

[rtl/gcode_line_validator_core.sv]
// Flow: a byte accepted into the input register is parsed once the result buffer has room; a verdict it
// causes is written into the result buffer and offered on the output from the cycle after that write.
// Throughput: one byte per cycle, set by the single input register and the
// two-entry result buffer; in_stall rises only when that buffer is full.
// Reset (arst_n low, asynchronous): line state cleared, last good line 0,
// fault period 0 (never), result buffer empty.
module gcode_line_validator_core #(
	parameter int LINE_CAPACITY = gclv_pkg::LINE_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] line_number,
	output logic        has_number,
	output logic        line_reset,
	output logic [31:0] last_good_line,
	output logic [31:0] resend_line,
	output logic        ok_after_resend,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] resend_every
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              room;
	logic              proc;
	logic              emit;
	gclv_pkg::result_t result;
	gclv_pkg::result_t out_data;

	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;

	// input register: hold the beat while the result buffer is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) valid_s1 <= 1'b1;
			else if (proc) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= rx_byte;
	end

	gclv_parser #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.byte_in (byte_s1),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(resend_every),
		.emit    (emit),
		.result  (result)
	);

	gclv_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.push_data(result),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign status          = out_data.status;
	assign line_number     = out_data.line_number;
	assign has_number      = out_data.has_number;
	assign line_reset      = out_data.line_reset;
	assign last_good_line  = out_data.last_good_line;
	assign resend_line     = out_data.resend_line;
	assign ok_after_resend = out_data.ok_after_resend;

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> room)
		else $error("verdict produced with no buffer room");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && (byte_s1 == $past(byte_s1)))
		else $error("held input beat lost while stalled");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

endmodule
